// ===== hdl/jsf32_pkg.sv =====
// Shared types, constants and round function of the jsf32 generator.
package jsf32_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned SeedW  = 64;
  localparam int unsigned CountW = 5;

  localparam logic [WordW-1:0] SeedMix = 32'hf1ea5eed;

  localparam logic [CountW-1:0] RoundsSeed  = 5'd20;
  localparam logic [CountW-1:0] RoundsFast  = 5'd8;
  localparam logic [CountW-1:0] RoundsWords = 5'd12;

  typedef enum logic [1:0] {
    OP_NEXT    = 2'd0,
    OP_SEED128 = 2'd1,
    OP_SEED64  = 2'd2,
    OP_WORDS   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } jsf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // load the state words from the item
    op_e  load_op;  // which seeding rule to load with
    logic step;     // apply one round to the state words
    logic emit;     // capture the new word d as a result
  } dp_cmd_t;

  localparam jsf_state_t FixedPoints [6] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
    '{32'h77777777, 32'h55555555, 32'h11111111, 32'h44444444},
    '{32'h5591F2E3, 32'h69EBA6CD, 32'h2A171E3D, 32'h3FD48890},
    '{32'h47CB8D56, 32'hAE9B35A7, 32'h5C78F4A8, 32'h522240FF},
    '{32'h71AAC8F9, 32'h66B4F5D3, 32'h1E950B8F, 32'h481FEA44},
    '{32'hAB23E5C6, 32'hD3D74D9A, 32'h542E3C7A, 32'h7FA91120}
  };

  function automatic jsf_state_t jsf_round(input jsf_state_t s);
    logic [WordW-1:0] e;
    jsf_state_t       n;
    e   = s.a - {s.b[4:0], s.b[31:5]};
    n.a = s.b ^ {s.c[14:0], s.c[31:15]};
    n.b = s.c + s.d;
    n.c = s.d + e;
    n.d = e + n.a;
    return n;
  endfunction

  function automatic logic is_fixed_point(input jsf_state_t s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (s == FixedPoints[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== hdl/jsf32_ctrl.sv =====
// Controller: handshakes, round counter and output valid flag.
module jsf32_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output jsf32_pkg::dp_cmd_t                cmd_o
);

  jsf32_pkg::ctrl_state_e          state_q, state_d;
  logic [jsf32_pkg::CountW-1:0]    count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  logic                            accept;
  jsf32_pkg::op_e                  op;

  assign op = jsf32_pkg::op_e'(op_i);

  // Take an item only when idle and the result slot is free or draining.
  assign in_stall_o  = !((state_q == jsf32_pkg::ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jsf32_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cmd_o.load    = 1'b0;
    cmd_o.load_op = op;
    cmd_o.step    = 1'b0;
    cmd_o.emit    = 1'b0;
    case (state_q)
      jsf32_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            jsf32_pkg::OP_NEXT: begin
              cmd_o.step = 1'b1;
              cmd_o.emit = 1'b1;
            end
            jsf32_pkg::OP_SEED128: begin
              cmd_o.load = 1'b1;
              count_d    = jsf32_pkg::RoundsSeed;
              state_d    = jsf32_pkg::ST_RUN;
            end
            jsf32_pkg::OP_SEED64: begin
              cmd_o.load = 1'b1;
              count_d    = jsf32_pkg::RoundsFast;
              state_d    = jsf32_pkg::ST_RUN;
            end
            default: begin
              cmd_o.load = 1'b1;
              count_d    = jsf32_pkg::RoundsWords;
              state_d    = jsf32_pkg::ST_RUN;
            end
          endcase
        end
      end
      jsf32_pkg::ST_RUN: begin
        cmd_o.step = 1'b1;
        count_d    = count_q - 1'b1;
        if (count_q == 5'd1) begin
          state_d = jsf32_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jsf32_pkg::ST_IDLE;
        count_d = '0;
      end
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  a_run_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jsf32_pkg::ST_RUN |-> count_q != '0)
    else $error("round counter empty while running");

  a_seed_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op != jsf32_pkg::OP_NEXT |=> state_q == jsf32_pkg::ST_RUN && count_q != '0)
    else $error("seeding transfer did not start the round loop");

  a_last_round_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jsf32_pkg::ST_RUN && count_q == 5'd1 |=> state_q == jsf32_pkg::ST_IDLE)
    else $error("round loop overran its count");

  a_no_emit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jsf32_pkg::ST_RUN |=> !($rose(out_valid_q)))
    else $error("result raised by a seeding op");

endmodule

// ===== hdl/jsf32_dp.sv =====
// Datapath: state words, seed loading, round unit and result register.
module jsf32_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  jsf32_pkg::dp_cmd_t                cmd_i,
  input  logic [jsf32_pkg::SeedW-1:0]       seed_lo_i,
  input  logic [jsf32_pkg::SeedW-1:0]       seed_hi_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_one_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_two_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_three_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_four_i,
  output logic [jsf32_pkg::WordW-1:0]       random_value_o
);

  jsf32_pkg::jsf_state_t        state_q, state_d;
  jsf32_pkg::jsf_state_t        stepped;
  jsf32_pkg::jsf_state_t        loaded;
  jsf32_pkg::jsf_state_t        raw_words;
  logic [jsf32_pkg::WordW-1:0]  value_q;
  logic [jsf32_pkg::WordW-1:0]  lo_l, lo_h, hi_l, hi_h;

  assign lo_l = seed_lo_i[31:0];
  assign lo_h = seed_lo_i[63:32];
  assign hi_l = seed_hi_i[31:0];
  assign hi_h = seed_hi_i[63:32];

  assign stepped   = jsf32_pkg::jsf_round(state_q);
  assign raw_words = '{a: word_one_i, b: word_two_i, c: word_three_i, d: word_four_i};

  always_comb begin
    loaded = raw_words;
    case (cmd_i.load_op)
      jsf32_pkg::OP_SEED128: begin
        loaded.a = jsf32_pkg::SeedMix ^ lo_h;
        loaded.b = lo_l;
        loaded.c = lo_l ^ lo_h ^ hi_l;
        loaded.d = lo_l ^ hi_h;
      end
      jsf32_pkg::OP_SEED64: begin
        loaded.a = jsf32_pkg::SeedMix ^ lo_h;
        loaded.b = lo_l;
        loaded.c = lo_l ^ lo_h;
        loaded.d = lo_l;
      end
      default: begin
        // Nudge a loaded fixed point off its orbit.
        if (jsf32_pkg::is_fixed_point(raw_words)) begin
          loaded.d = word_four_i + 32'd1;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (cmd_i.load) begin
      state_d = loaded;
    end else if (cmd_i.step) begin
      state_d = stepped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      value_q <= stepped.d;
    end
  end

  assign random_value_o = value_q;

  a_emit_is_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> cmd_i.step && !cmd_i.load)
    else $error("result captured without a round");

  a_emit_tracks_d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> value_q == state_q.d)
    else $error("result differs from new word d");

  a_load_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load && !cmd_i.step |=> $stable(state_q))
    else $error("state words moved without a command");

endmodule

// ===== hdl/jsf32_prng_with_seeding.sv =====
// Top level of the jsf32 pseudo-random generator with seeding ops.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | op_i, seed_lo_i, seed_hi_i, word_*_i
//  out     | output    | out_valid_o / out_stall_i | random_value_o
//
// Op next: one round is applied and the new word d is registered as the result,
// so a steady stream gives one value per cycle while out is not stalled.
// Seeding ops: a load, then one round per cycle from the single round unit,
// RoundsSeed (128-bit seed), RoundsFast (64-bit seed) or RoundsWords (four
// words) rounds; input stalls until the last round is done.
// Reset clears the four state words (generator starts in the all-zero state).
// Input stalls while a result waits in the output register and out is stalled.
module jsf32_prng_with_seeding (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic [jsf32_pkg::SeedW-1:0]       seed_lo_i,
  input  logic [jsf32_pkg::SeedW-1:0]       seed_hi_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_one_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_two_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_three_i,
  input  logic [jsf32_pkg::WordW-1:0]       word_four_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [jsf32_pkg::WordW-1:0]       random_value_o
);

  // Command bundle: load, step and emit strobes and the load op from the controller.
  jsf32_pkg::dp_cmd_t cmd;

  jsf32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: hold the state words, load seeds, advance one round per step.
  jsf32_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .seed_lo_i      (seed_lo_i),
    .seed_hi_i      (seed_hi_i),
    .word_one_i     (word_one_i),
    .word_two_i     (word_two_i),
    .word_three_i   (word_three_i),
    .word_four_i    (word_four_i),
    .random_value_o (random_value_o)
  );

endmodule
